// ===== rtl/ofs_pkg.sv =====
package ofs_pkg;

    localparam int unsigned ModeW  = 5;
    localparam int unsigned WordW  = 16;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned InDataW  = 80;
    localparam int unsigned OutDataW = 88;

    localparam logic [WordW-1:0] HIGH_PAGE = 16'hFF00;

    localparam logic [ModeW-1:0] M_IMP    = 5'd0;
    localparam logic [ModeW-1:0] M_R      = 5'd1;
    localparam logic [ModeW-1:0] M_R_R    = 5'd2;
    localparam logic [ModeW-1:0] M_R_D8   = 5'd3;
    localparam logic [ModeW-1:0] M_R_D16  = 5'd4;
    localparam logic [ModeW-1:0] M_R_A8   = 5'd5;
    localparam logic [ModeW-1:0] M_R_A16  = 5'd6;
    localparam logic [ModeW-1:0] M_R_MR   = 5'd7;
    localparam logic [ModeW-1:0] M_R_HLI  = 5'd8;
    localparam logic [ModeW-1:0] M_R_HLD  = 5'd9;
    localparam logic [ModeW-1:0] M_MR     = 5'd10;
    localparam logic [ModeW-1:0] M_MR_R   = 5'd11;
    localparam logic [ModeW-1:0] M_MR_D8  = 5'd12;
    localparam logic [ModeW-1:0] M_HL_SPR = 5'd13;
    localparam logic [ModeW-1:0] M_HLI_R  = 5'd14;
    localparam logic [ModeW-1:0] M_HLD_R  = 5'd15;
    localparam logic [ModeW-1:0] M_D8     = 5'd16;
    localparam logic [ModeW-1:0] M_D16    = 5'd17;
    localparam logic [ModeW-1:0] M_D16_R  = 5'd18;
    localparam logic [ModeW-1:0] M_A8_R   = 5'd19;
    localparam logic [ModeW-1:0] M_A16_R  = 5'd20;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_BYTE1 = 2'd1;
    localparam logic [1:0] PH_BYTE2 = 2'd2;
    localparam logic [1:0] PH_BYTE3 = 2'd3;

    localparam logic REQ_DISPATCH = 1'b0;

    typedef struct packed {
        logic [1:0]       phase;
        logic [ModeW-1:0] mode;
        logic [ByteW-1:0] low_byte;
        logic [WordW-1:0] pc;
        logic [WordW-1:0] first_reg;
        logic [WordW-1:0] second_reg;
        logic [WordW-1:0] hl;
        logic [1:0]       cycle_count;
    } t_state;

    typedef struct packed {
        logic             kind;
        logic [WordW-1:0] read_addr;
        logic [WordW-1:0] operand;
        logic [WordW-1:0] dest_addr;
        logic             dest_in_memory;
        logic [WordW-1:0] pc_out;
        logic [WordW-1:0] hl_out;
        logic             hl_write;
        logic [1:0]       bus_cycles;
        logic             bad_mode;
    } t_result;

endpackage

// ===== rtl/ofs_step.sv =====
module ofs_step
    import ofs_pkg::*;
(
    input  logic             i_req_type,
    input  logic [ModeW-1:0] i_mode,
    input  logic [WordW-1:0] i_first_reg_value,
    input  logic [WordW-1:0] i_second_reg_value,
    input  logic             i_first_is_c,
    input  logic             i_second_is_c,
    input  logic [WordW-1:0] i_prog_counter,
    input  logic [WordW-1:0] i_hl_value,
    input  logic [ByteW-1:0] i_bus_byte,
    input  t_state           i_state,
    output t_state           o_state,
    output t_result          o_result,
    output logic             o_emit
);

    t_state           n;
    logic             fin;
    logic [WordW-1:0] rd_addr;
    logic [1:0]       nph;
    logic [WordW-1:0] opnd;
    logic [WordW-1:0] dst;
    logic             mem;
    logic [1:0]       adv;
    logic             inc;
    logic             dec;
    logic             bad;
    logic [WordW-1:0] word;

    assign word = {i_bus_byte, i_state.low_byte};

    always_comb begin
        n       = i_state;
        o_emit  = 1'b0;
        fin     = 1'b0;
        rd_addr = '0;
        nph     = PH_IDLE;
        opnd    = '0;
        dst     = '0;
        mem     = 1'b0;
        adv     = 2'd0;
        inc     = 1'b0;
        dec     = 1'b0;
        bad     = 1'b0;
        if (i_req_type == REQ_DISPATCH) begin
            n.mode        = i_mode;
            n.first_reg   = i_first_reg_value;
            n.second_reg  = i_second_reg_value;
            n.pc          = i_prog_counter;
            n.hl          = i_hl_value;
            n.low_byte    = '0;
            n.cycle_count = 2'd0;
            o_emit        = 1'b1;
            unique case (i_mode)
                M_IMP: fin = 1'b1;
                M_R: begin
                    fin  = 1'b1;
                    opnd = i_first_reg_value;
                end
                M_R_R: begin
                    fin  = 1'b1;
                    opnd = i_second_reg_value;
                end
                M_MR_R: begin
                    fin  = 1'b1;
                    opnd = i_second_reg_value;
                    dst  = i_first_is_c ? (i_first_reg_value | HIGH_PAGE) : i_first_reg_value;
                    mem  = 1'b1;
                end
                M_HLI_R, M_HLD_R: begin
                    fin  = 1'b1;
                    opnd = i_second_reg_value;
                    dst  = i_first_reg_value;
                    mem  = 1'b1;
                    inc  = (i_mode == M_HLI_R);
                    dec  = (i_mode == M_HLD_R);
                end
                M_R_MR: begin
                    rd_addr = i_second_is_c ? (i_second_reg_value | HIGH_PAGE)
                                            : i_second_reg_value;
                    nph     = PH_BYTE1;
                end
                M_R_HLI, M_R_HLD: begin
                    rd_addr = i_second_reg_value;
                    nph     = PH_BYTE1;
                end
                M_MR: begin
                    rd_addr = i_first_reg_value;
                    nph     = PH_BYTE1;
                end
                M_R_D8, M_R_D16, M_R_A8, M_R_A16, M_MR_D8, M_HL_SPR,
                M_D8, M_D16, M_D16_R, M_A8_R, M_A16_R: begin
                    rd_addr = i_prog_counter;
                    nph     = PH_BYTE1;
                end
                default: begin
                    fin = 1'b1;
                    bad = 1'b1;
                end
            endcase
        end else if (i_state.phase != PH_IDLE) begin
            o_emit        = 1'b1;
            n.cycle_count = i_state.cycle_count + 2'd1;
            priority if (i_state.phase == PH_BYTE1 &&
                         (i_state.mode == M_R_D16 || i_state.mode == M_R_A16 ||
                          i_state.mode == M_D16 || i_state.mode == M_D16_R ||
                          i_state.mode == M_A16_R)) begin
                n.low_byte = i_bus_byte;
                rd_addr    = i_state.pc + 16'd1;
                nph        = PH_BYTE2;
            end else if (i_state.phase == PH_BYTE2 && i_state.mode == M_R_A16) begin
                rd_addr = word;
                nph     = PH_BYTE3;
            end else begin
                fin = 1'b1;
                unique case (i_state.mode)
                    M_R_D8, M_R_A8, M_HL_SPR, M_D8: begin
                        opnd = {8'd0, i_bus_byte};
                        adv  = 2'd1;
                    end
                    M_R_D16, M_D16: begin
                        opnd = word;
                        adv  = 2'd2;
                    end
                    M_R_MR: opnd = {8'd0, i_bus_byte};
                    M_R_HLI: begin
                        opnd = {8'd0, i_bus_byte};
                        inc  = 1'b1;
                    end
                    M_R_HLD: begin
                        opnd = {8'd0, i_bus_byte};
                        dec  = 1'b1;
                    end
                    M_MR: begin
                        opnd = {8'd0, i_bus_byte};
                        dst  = i_state.first_reg;
                        mem  = 1'b1;
                    end
                    M_MR_D8: begin
                        opnd = {8'd0, i_bus_byte};
                        dst  = i_state.first_reg;
                        mem  = 1'b1;
                        adv  = 2'd1;
                    end
                    M_D16_R, M_A16_R: begin
                        opnd = i_state.second_reg;
                        dst  = word;
                        mem  = 1'b1;
                        adv  = 2'd2;
                    end
                    M_A8_R: begin
                        opnd = i_state.second_reg;
                        dst  = {8'd0, i_bus_byte} | HIGH_PAGE;
                        mem  = 1'b1;
                        adv  = 2'd1;
                    end
                    default: begin
                        opnd = {8'd0, i_bus_byte};
                        adv  = 2'd2;
                    end
                endcase
            end
        end
        if (o_emit) begin
            n.phase = nph;
        end
    end

    always_comb begin
        o_result = '0;
        o_result.kind = fin;
        if (fin) begin
            o_result.operand        = opnd;
            o_result.dest_addr      = mem ? dst : '0;
            o_result.dest_in_memory = mem;
            o_result.pc_out         = n.pc + {14'd0, adv};
            o_result.hl_out         = inc ? (n.hl + 16'd1) :
                                      dec ? (n.hl - 16'd1) : n.hl;
            o_result.hl_write       = inc | dec;
            o_result.bus_cycles     = n.cycle_count;
            o_result.bad_mode       = bad;
        end else begin
            o_result.read_addr = rd_addr;
        end
    end

    assign o_state = n;

endmodule

// ===== rtl/ofs_out_reg.sv =====
module ofs_out_reg
    import ofs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  t_result             i_result,
    output logic                o_ready,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // read_addr, operand, dest_addr, dest_in_memory, pc_out, hl_out,
    // hl_write, bus_cycles, bad_mode, zero pad
    output logic [OutDataW-1:0] m_axis_tdata,
    // kind
    output logic                m_axis_tuser
);

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_result <= i_result;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tuser  = r_result.kind;
    assign m_axis_tdata  = {3'd0,
                            r_result.bad_mode,
                            r_result.bus_cycles,
                            r_result.hl_write,
                            r_result.hl_out,
                            r_result.pc_out,
                            r_result.dest_in_memory,
                            r_result.dest_addr,
                            r_result.operand,
                            r_result.read_addr};

endmodule

// ===== rtl/cpu_operand_fetch_sequencer_core.sv =====
// Operand-fetch sequencer for an 8-bit CPU.
// Slave stream: tuser = 0 dispatches an instruction (mode, register values,
// PC, HL in tdata); tuser = 1 delivers the byte returned by the last bus read.
// Master stream: tuser = 0 is a bus read request at read_addr; tuser = 1 ends
// the fetch with operand, destination, new PC, new HL and bus cycle count.
// Each request produces at most one result, registered and shown in the cycle after it is taken;
// a byte arriving while no fetch is pending is dropped without a result.
// A request is taken every cycle while the output register is empty or being
// drained, so throughput is one request per clock; each result is held in the
// single output register.
// If the receiver stalls with a result held, tready drops until it is taken.
// A dispatch while a fetch is pending abandons the old one.
// Reset clears the sequencer state and the output valid.
module cpu_operand_fetch_sequencer_core
    import ofs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // mode, first_reg_value, second_reg_value, first_is_c, second_is_c,
    // prog_counter, hl_value, bus_byte, zero pad
    input  logic [InDataW-1:0]  s_axis_tdata,
    // req_type
    input  logic                s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // read_addr, operand, dest_addr, dest_in_memory, pc_out, hl_out,
    // hl_write, bus_cycles, bad_mode, zero pad
    output logic [OutDataW-1:0] m_axis_tdata,
    // kind
    output logic                m_axis_tuser
);

    t_state  r_state;
    t_state  n_state;
    t_result step_result;
    logic    step_emit;
    logic    ready;
    logic    accept;

    assign s_axis_tready = ready;
    assign accept        = s_axis_tvalid && ready;

    ofs_step u_step (
        .i_req_type         (s_axis_tuser),
        .i_mode             (s_axis_tdata[4:0]),
        .i_first_reg_value  (s_axis_tdata[20:5]),
        .i_second_reg_value (s_axis_tdata[36:21]),
        .i_first_is_c       (s_axis_tdata[37]),
        .i_second_is_c      (s_axis_tdata[38]),
        .i_prog_counter     (s_axis_tdata[54:39]),
        .i_hl_value         (s_axis_tdata[70:55]),
        .i_bus_byte         (s_axis_tdata[78:71]),
        .i_state            (r_state),
        .o_state            (n_state),
        .o_result           (step_result),
        .o_emit             (step_emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    ofs_out_reg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (accept && step_emit),
        .i_result      (step_result),
        .o_ready       (ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== bench/cpu_operand_fetch_sequencer_core_test.sv =====
`timescale 1ns / 1ps

module cpu_operand_fetch_sequencer_core_test;
    import ofs_pkg::*;

    localparam logic [ModeW-1:0] MODE_FIRST_BAD = 5'd21;
    localparam logic [ModeW-1:0] MODE_TOP       = 5'd31;
    localparam logic             REQ_BYTE       = 1'b1;
    localparam int unsigned      QUIET_LIMIT    = 3000;
    localparam int unsigned      HOLD_OFF       = 200;

    typedef struct packed {
        logic             req_type;
        logic [ModeW-1:0] mode;
        logic [WordW-1:0] reg_a;
        logic [WordW-1:0] reg_b;
        logic             a_is_c;
        logic             b_is_c;
        logic [WordW-1:0] pc;
        logic [WordW-1:0] hl;
        logic [ByteW-1:0] data;
    } t_fetch_req;

    typedef struct {
        t_fetch_req req;
        bit         typed;
        t_result    want;
    } t_plan_row;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata  = '0;
    logic                s_axis_tuser  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                m_axis_tuser;

    // sequencer mirror
    logic [1:0]       fetch_phase = PH_IDLE;
    logic [ModeW-1:0] fetch_mode  = '0;
    logic [ByteW-1:0] lo_byte     = '0;
    logic [WordW-1:0] fetch_pc    = '0;
    logic [WordW-1:0] reg_a_held  = '0;
    logic [WordW-1:0] reg_b_held  = '0;
    logic [WordW-1:0] hl_held     = '0;
    logic [1:0]       reads_done  = '0;

    t_result     fetch_results[$];
    int unsigned results_caused = 0;
    int unsigned errors         = 0;
    int unsigned src_idle_pct   = 17;
    int unsigned sink_idle_pct  = 85;
    bit          stall_request  = 1'b0;
    bit          stall_seen     = 1'b0;
    int unsigned stall_left     = 0;
    int unsigned quiet_cycles   = 0;

    cpu_operand_fetch_sequencer_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic logic [InDataW-1:0] pack_fetch_req(input t_fetch_req r);
        return {1'b0, r.data, r.hl, r.pc, r.b_is_c, r.a_is_c, r.reg_b, r.reg_a, r.mode};
    endfunction

    function automatic t_result unpack_fetch_result(input logic [OutDataW-1:0] d,
                                                    input logic k);
        t_result u;
        u.kind           = k;
        u.read_addr      = d[15:0];
        u.operand        = d[31:16];
        u.dest_addr      = d[47:32];
        u.dest_in_memory = d[48];
        u.pc_out         = d[64:49];
        u.hl_out         = d[80:65];
        u.hl_write       = d[81];
        u.bus_cycles     = d[83:82];
        u.bad_mode       = d[84];
        return u;
    endfunction

    function automatic t_result fetch_done(input logic [WordW-1:0] operand,
                                           input logic [WordW-1:0] dest, input bit mem,
                                           input logic [WordW-1:0] pc_adv,
                                           input int hl_step, input bit bad);
        t_result res;
        res                = '0;
        res.kind           = 1'b1;
        res.operand        = operand;
        res.dest_addr      = mem ? dest : '0;
        res.dest_in_memory = mem;
        res.pc_out         = fetch_pc + pc_adv;
        res.hl_out         = hl_held + 16'(hl_step);
        res.hl_write       = (hl_step != 0);
        res.bus_cycles     = reads_done;
        res.bad_mode       = bad;
        fetch_phase        = PH_IDLE;
        return res;
    endfunction

    function automatic t_result fetch_read(input logic [WordW-1:0] addr,
                                           input logic [1:0] next_phase);
        t_result res;
        res           = '0;
        res.read_addr = addr;
        fetch_phase   = next_phase;
        return res;
    endfunction

    function automatic t_result last_read(input logic [ByteW-1:0] b);
        logic [WordW-1:0] word;
        word = {b, lo_byte};
        case (fetch_mode)
            M_R_D8, M_R_A8, M_HL_SPR, M_D8: return fetch_done({8'h00, b}, '0, 0, 1, 0, 0);
            M_R_D16, M_D16:                 return fetch_done(word, '0, 0, 2, 0, 0);
            M_R_MR:                         return fetch_done({8'h00, b}, '0, 0, 0, 0, 0);
            M_R_HLI:                        return fetch_done({8'h00, b}, '0, 0, 0, 1, 0);
            M_R_HLD:                        return fetch_done({8'h00, b}, '0, 0, 0, -1, 0);
            M_MR:                           return fetch_done({8'h00, b}, reg_a_held, 1, 0, 0, 0);
            M_MR_D8:                        return fetch_done({8'h00, b}, reg_a_held, 1, 1, 0, 0);
            M_D16_R, M_A16_R:               return fetch_done(reg_b_held, word, 1, 2, 0, 0);
            M_A8_R: return fetch_done(reg_b_held, HIGH_PAGE | {8'h00, b}, 1, 1, 0, 0);
            default:                        return fetch_done({8'h00, b}, '0, 0, 2, 0, 0);
        endcase
    endfunction

    function automatic bit predict_fetch(input t_fetch_req r, output t_result res);
        res = '0;
        if (r.req_type == REQ_DISPATCH) begin
            fetch_mode  = r.mode;
            reg_a_held  = r.reg_a;
            reg_b_held  = r.reg_b;
            fetch_pc    = r.pc;
            hl_held     = r.hl;
            lo_byte     = '0;
            reads_done  = '0;
            fetch_phase = PH_IDLE;
            case (r.mode)
                M_IMP:   res = fetch_done('0, '0, 0, 0, 0, 0);
                M_R:     res = fetch_done(reg_a_held, '0, 0, 0, 0, 0);
                M_R_R:   res = fetch_done(reg_b_held, '0, 0, 0, 0, 0);
                M_MR_R:  res = fetch_done(reg_b_held,
                                          r.a_is_c ? (reg_a_held | HIGH_PAGE) : reg_a_held,
                                          1, 0, 0, 0);
                M_HLI_R: res = fetch_done(reg_b_held, reg_a_held, 1, 0, 1, 0);
                M_HLD_R: res = fetch_done(reg_b_held, reg_a_held, 1, 0, -1, 0);
                M_R_MR:  res = fetch_read(r.b_is_c ? (reg_b_held | HIGH_PAGE) : reg_b_held,
                                          PH_BYTE1);
                M_R_HLI, M_R_HLD: res = fetch_read(reg_b_held, PH_BYTE1);
                M_MR:    res = fetch_read(reg_a_held, PH_BYTE1);
                M_R_D8, M_R_D16, M_R_A8, M_R_A16, M_MR_D8, M_HL_SPR,
                M_D8, M_D16, M_D16_R, M_A8_R, M_A16_R:
                         res = fetch_read(fetch_pc, PH_BYTE1);
                default: res = fetch_done('0, '0, 0, 0, 0, 1);
            endcase
            return 1'b1;
        end
        if (fetch_phase == PH_IDLE) return 1'b0;
        reads_done = reads_done + 2'd1;
        if (fetch_phase == PH_BYTE1 && (fetch_mode == M_R_D16 || fetch_mode == M_R_A16 ||
                fetch_mode == M_D16 || fetch_mode == M_D16_R || fetch_mode == M_A16_R)) begin
            lo_byte = r.data;
            res = fetch_read(fetch_pc + 16'd1, PH_BYTE2);
        end else if (fetch_phase == PH_BYTE2 && fetch_mode == M_R_A16) begin
            res = fetch_read({r.data, lo_byte}, PH_BYTE3);
        end else begin
            res = last_read(r.data);
        end
        return 1'b1;
    endfunction

    function automatic t_fetch_req dispatch_of(input logic [ModeW-1:0] mode,
                                               input logic [WordW-1:0] ra, rb,
                                               input logic ca, cb,
                                               input logic [WordW-1:0] pc, hl);
        t_fetch_req r;
        r = '{req_type: REQ_DISPATCH, mode: mode, reg_a: ra, reg_b: rb, a_is_c: ca,
              b_is_c: cb, pc: pc, hl: hl, data: '0};
        return r;
    endfunction

    function automatic t_fetch_req byte_of(input logic [ByteW-1:0] b);
        t_fetch_req r;
        r          = '0;
        r.req_type = REQ_BYTE;
        r.data     = b;
        return r;
    endfunction

    function automatic t_result finished(input logic [WordW-1:0] operand, dest,
                                         input logic mem, input logic [WordW-1:0] pc, hl,
                                         input logic hlw, input logic [1:0] cyc,
                                         input logic bad);
        t_result res;
        res = '{kind: 1'b1, read_addr: '0, operand: operand, dest_addr: dest,
                dest_in_memory: mem, pc_out: pc, hl_out: hl, hl_write: hlw,
                bus_cycles: cyc, bad_mode: bad};
        return res;
    endfunction

    function automatic t_plan_row row(input t_fetch_req req);
        t_plan_row p;
        p.req   = req;
        p.typed = 1'b0;
        p.want  = '0;
        return p;
    endfunction

    function automatic t_plan_row row_want(input t_fetch_req req, input t_result want);
        t_plan_row p;
        p.req   = req;
        p.typed = 1'b1;
        p.want  = want;
        return p;
    endfunction

    function automatic logic [WordW-1:0] edgy_word();
        case ($urandom_range(0, 7))
            0:       return 16'hFFFF;
            1:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_fetch_req rand_req(input logic kind);
        t_fetch_req r;
        r.req_type = kind;
        r.mode     = ($urandom_range(0, 99) < 6)
                         ? ModeW'($urandom_range(MODE_FIRST_BAD, MODE_TOP))
                         : ModeW'($urandom_range(M_IMP, M_A16_R));
        r.reg_a    = edgy_word();
        r.reg_b    = edgy_word();
        r.a_is_c   = 1'($urandom_range(0, 1));
        r.b_is_c   = 1'($urandom_range(0, 1));
        r.pc       = edgy_word();
        r.hl       = edgy_word();
        r.data     = ByteW'($urandom_range(0, 255));
        return r;
    endfunction

    task automatic offer(input t_fetch_req r, input bit typed, input t_result want);
        t_result res;
        bit      has;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_fetch_req(r);
        s_axis_tuser  <= r.req_type;
        do @(posedge i_clk); while (!s_axis_tready);
        has = predict_fetch(r, res);
        if (has) begin
            fetch_results.push_back(typed ? want : res);
            results_caused++;
        end
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // one dispatch plus its bytes; sometimes a stray byte first or a cut-off fetch
    task automatic random_fetch();
        if ($urandom_range(0, 99) < 8)
            offer(rand_req(REQ_BYTE), 1'b0, '0);
        offer(rand_req(REQ_DISPATCH), 1'b0, '0);
        while (fetch_phase != PH_IDLE) begin
            if ($urandom_range(0, 99) < 4) break;
            offer(rand_req(REQ_BYTE), 1'b0, '0);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (fetch_results.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (stall_request != stall_seen) begin
            stall_seen    <= stall_request;
            stall_left    <= HOLD_OFF;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = unpack_fetch_result(m_axis_tdata, m_axis_tuser);
            if (fetch_results.size() == 0) begin
                $error("result with nothing pending: kind %0d read_addr 0x%0h",
                       got.kind, got.read_addr);
                errors++;
            end else begin
                want = fetch_results.pop_front();
                check_field("kind", want.kind, got.kind);
                check_field("read_addr", want.read_addr, got.read_addr);
                check_field("operand", want.operand, got.operand);
                check_field("dest_addr", want.dest_addr, got.dest_addr);
                check_field("dest_in_memory", want.dest_in_memory, got.dest_in_memory);
                check_field("pc_out", want.pc_out, got.pc_out);
                check_field("hl_out", want.hl_out, got.hl_out);
                check_field("hl_write", want.hl_write, got.hl_write);
                check_field("bus_cycles", want.bus_cycles, got.bus_cycles);
                check_field("bad_mode", want.bad_mode, got.bad_mode);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("cpu_operand_fetch_sequencer_core_test: done, errors");
            $finish;
        end
    end

    initial begin : stimulus
        t_plan_row   plan[$];
        int unsigned target;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // byte with nothing pending: dropped
        plan.push_back(row(byte_of(8'hAB)));
        plan.push_back(row_want(dispatch_of(M_IMP, 16'hFFFF, 16'hFFFF, 1, 1, 16'hFFFF, 16'h0000),
                                finished(16'h0, 16'h0, 0, 16'hFFFF, 16'h0000, 0, 0, 0)));
        plan.push_back(row_want(dispatch_of(MODE_TOP, 16'hFFFF, 16'hFFFF, 1, 1,
                                            16'h1234, 16'hFFFF),
                                finished(16'h0, 16'h0, 0, 16'h1234, 16'hFFFF, 0, 0, 1)));
        plan.push_back(row_want(dispatch_of(M_R, 16'hFFFF, 16'h0000, 0, 0, 16'h0000, 16'h0000),
                                finished(16'hFFFF, 16'h0, 0, 16'h0000, 16'h0000, 0, 0, 0)));
        plan.push_back(row(dispatch_of(M_R_R, 16'h0000, 16'hBEEF, 0, 1, 16'h0010, 16'h0020)));
        plan.push_back(row(dispatch_of(M_MR_R, 16'h0012, 16'h00A5, 1, 0, 16'h0100, 16'h2000)));
        plan.push_back(row_want(dispatch_of(M_HLI_R, 16'hC000, 16'h0077, 0, 0,
                                            16'h0200, 16'hFFFF),
                                finished(16'h0077, 16'hC000, 1, 16'h0200, 16'h0000, 1, 0, 0)));
        plan.push_back(row_want(dispatch_of(M_HLD_R, 16'hD000, 16'h0088, 0, 0,
                                            16'h0300, 16'h0000),
                                finished(16'h0088, 16'hD000, 1, 16'h0300, 16'hFFFF, 1, 0, 0)));
        // each of these is abandoned by the next dispatch
        plan.push_back(row(dispatch_of(M_R_D8, 16'h1111, 16'h2222, 0, 0, 16'h0400, 16'h0500)));
        plan.push_back(row(dispatch_of(M_R_A8, 16'h1111, 16'h2222, 0, 0, 16'h0410, 16'h0500)));
        plan.push_back(row(dispatch_of(M_MR, 16'h8000, 16'h2222, 1, 0, 16'h0420, 16'h0500)));
        plan.push_back(row(dispatch_of(M_MR_D8, 16'h9000, 16'h2222, 0, 0, 16'h0430, 16'h0500)));
        plan.push_back(row(dispatch_of(M_HL_SPR, 16'h1111, 16'h2222, 0, 0, 16'h0440, 16'h0500)));
        plan.push_back(row(dispatch_of(M_D8, 16'h1111, 16'h2222, 0, 0, 16'h0450, 16'h0500)));
        plan.push_back(row(dispatch_of(M_D16, 16'h1111, 16'h2222, 0, 0, 16'h0460, 16'h0500)));
        plan.push_back(row(dispatch_of(M_D16_R, 16'h1111, 16'h2222, 0, 0, 16'h0470, 16'h0500)));
        plan.push_back(row(dispatch_of(M_A16_R, 16'h1111, 16'h2222, 0, 0, 16'h0480, 16'h0500)));
        // 16-bit immediate with PC wrap
        plan.push_back(row(dispatch_of(M_R_D16, 16'h0000, 16'h0000, 0, 0, 16'hFFFF, 16'h0600)));
        plan.push_back(row(byte_of(8'h34)));
        plan.push_back(row_want(byte_of(8'h12),
                                finished(16'h1234, 16'h0, 0, 16'h0001, 16'h0600, 0, 2, 0)));
        plan.push_back(row(dispatch_of(M_R_A16, 16'h0000, 16'h0000, 0, 0, 16'h4000, 16'h0700)));
        plan.push_back(row(byte_of(8'h00)));
        plan.push_back(row(byte_of(8'hC0)));
        plan.push_back(row(byte_of(8'hFF)));
        plan.push_back(row(dispatch_of(M_R_MR, 16'h0000, 16'h0005, 0, 1, 16'h0800, 16'h0900)));
        plan.push_back(row(byte_of(8'h5A)));
        plan.push_back(row(dispatch_of(M_R_HLI, 16'h0000, 16'h3000, 0, 0, 16'h0A00, 16'hFFFF)));
        plan.push_back(row(byte_of(8'h00)));
        plan.push_back(row(dispatch_of(M_R_HLD, 16'h0000, 16'h3100, 0, 0, 16'h0B00, 16'h0000)));
        plan.push_back(row(byte_of(8'hFF)));
        plan.push_back(row(dispatch_of(M_A8_R, 16'h0000, 16'hABCD, 0, 0, 16'h0C00, 16'h0D00)));
        plan.push_back(row(byte_of(8'h80)));
        foreach (plan[i])
            offer(plan[i].req, plan[i].typed, plan[i].want);

        target = results_caused + 470;
        while (results_caused < target) random_fetch();

        src_idle_pct  = 85;
        sink_idle_pct = 17;
        target = results_caused + 470;
        while (results_caused < target) random_fetch();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        stall_request <= ~stall_request;
        target = results_caused + 40;
        while (results_caused < target) random_fetch();
        drain_results();
        target = results_caused + 430;
        while (results_caused < target) random_fetch();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("cpu_operand_fetch_sequencer_core_test: done, clean");
        else
            $display("cpu_operand_fetch_sequencer_core_test: done, errors");
        $finish;
    end

endmodule
